// File: src/cta_pkg.sv
`default_nettype none
package cta_pkg;

  localparam int unsigned InW    = 12;   // pixel coordinate width
  localparam int unsigned OrgW   = 32;   // origin register width
  localparam int unsigned StepW  = 18;   // step register width
  localparam int unsigned ProdW  = 31;   // coordinate times step
  localparam int unsigned RayW   = 34;   // ray component, never wraps
  localparam int unsigned NegW   = 35;   // ray component after sign flip
  localparam int unsigned MagW   = 34;   // depth magnitude
  localparam int unsigned AccW   = 52;   // projection numerator
  localparam int unsigned TexW   = 10;   // texel index width
  localparam int unsigned FaceW  = 3;
  localparam int unsigned OrdW   = 2;
  localparam int unsigned CntW   = 4;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // shrink factor 0.4999 as 32761/65536, scaled down by 2^10 with the face size
  localparam logic [AccW-1:0] ShrinkK = AccW'(32761);
  // depth shift that turns m into the divisor (64 * |d|)
  localparam int unsigned DivShift = 6;
  localparam int unsigned QuotMsb  = TexW - 1;

  localparam logic [OrdW-1:0] OrdLast = 2'd2;

  // register indexes
  localparam logic [2:0] RegOrgX  = 3'd0;
  localparam logic [2:0] RegOrgY  = 3'd1;
  localparam logic [2:0] RegOrgZ  = 3'd2;
  localparam logic [2:0] RegColX  = 3'd3;
  localparam logic [2:0] RegColZ  = 3'd4;
  localparam logic [2:0] RegRowX  = 3'd5;
  localparam logic [2:0] RegRowY  = 3'd6;
  localparam logic [2:0] RegRowZ  = 3'd7;

  typedef struct packed {
    logic signed [OrgW-1:0]  org_x;
    logic signed [OrgW-1:0]  org_y;
    logic signed [OrgW-1:0]  org_z;
    logic signed [StepW-1:0] col_x;
    logic signed [StepW-1:0] col_z;
    logic signed [StepW-1:0] row_x;
    logic signed [StepW-1:0] row_y;
    logic signed [StepW-1:0] row_z;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic sum;
    logic setup;
    logic advance;
    logic mul;
    logic chk;
    logic div_step;
    logic store;
    logic out_load;
    logic out_miss;
  } cmd_t;

  typedef struct packed {
    logic d_zero;
    logic in_range;
    logic div_last;
    logic sel_b;
  } status_t;

endpackage
`default_nettype wire

// File: src/cta_regs.sv
`default_nettype none
module cta_regs (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [cta_pkg::AddrW-1:0]   paddr,
  input  wire [cta_pkg::DataW-1:0]   pwdata,
  output logic [cta_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output cta_pkg::cfg_t              cfg_o
);
  import cta_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegOrgX: cfg_q.org_x <= pwdata;
        RegOrgY: cfg_q.org_y <= pwdata;
        RegOrgZ: cfg_q.org_z <= pwdata;
        RegColX: cfg_q.col_x <= pwdata[StepW-1:0];
        RegColZ: cfg_q.col_z <= pwdata[StepW-1:0];
        RegRowX: cfg_q.row_x <= pwdata[StepW-1:0];
        RegRowY: cfg_q.row_y <= pwdata[StepW-1:0];
        RegRowZ: cfg_q.row_z <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegOrgX: prdata = cfg_q.org_x;
      RegOrgY: prdata = cfg_q.org_y;
      RegOrgZ: prdata = cfg_q.org_z;
      RegColX: prdata = DataW'(cfg_q.col_x);
      RegColZ: prdata = DataW'(cfg_q.col_z);
      RegRowX: prdata = DataW'(cfg_q.row_x);
      RegRowY: prdata = DataW'(cfg_q.row_y);
      RegRowZ: prdata = DataW'(cfg_q.row_z);
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/cta_datapath.sv
`default_nettype none
module cta_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  cta_pkg::cfg_t                 cfg_i,
  input  wire [cta_pkg::InW-1:0]        col_i,
  input  wire [cta_pkg::InW-1:0]        row_i,
  input  wire                           frame_start_i,
  input  cta_pkg::cmd_t                 cmd_i,
  output cta_pkg::status_t              status_o,
  output logic [cta_pkg::FaceW-1:0]     face_o,
  output logic [cta_pkg::TexW-1:0]      texel_col_o,
  output logic [cta_pkg::TexW-1:0]      texel_row_o,
  output logic                          miss_o
);
  import cta_pkg::*;

  logic [InW-1:0]          col_q, row_q;
  logic signed [ProdW-1:0] p_cx_q, p_rx_q, p_ry_q, p_cz_q, p_rz_q;
  logic signed [RayW-1:0]  c_q [3];
  logic [OrdW-1:0]         ord_q, k_q;
  logic signed [RayW-1:0]  a_sel, b_sel, d_sel;
  logic signed [NegW-1:0]  an_q, bn_q;
  logic [MagW-1:0]         dm_q;
  logic                    dpos_q, sel_q;
  logic signed [AccW-1:0]  src, s_d, s_q, dext, diff;
  logic [AccW-1:0]         rem_q, dv_q;
  logic [CntW-1:0]         cnt_q;
  logic [TexW-1:0]         q_q, xi_q, yi_q;
  logic                    neg;

  // axis order: 0 (x,y,z), 1 (y,z,x), 2 (z,x,y)
  always_comb begin
    unique case (k_q)
      2'd1:    begin a_sel = c_q[1]; b_sel = c_q[2]; d_sel = c_q[0]; end
      2'd2:    begin a_sel = c_q[2]; b_sel = c_q[0]; d_sel = c_q[1]; end
      default: begin a_sel = c_q[0]; b_sel = c_q[1]; d_sel = c_q[2]; end
    endcase
  end

  assign neg  = d_sel[RayW-1];
  assign src  = sel_q ? AccW'(bn_q) : AccW'(an_q);
  assign dext = $signed({{(AccW-MagW-DivShift){1'b0}}, dm_q, {DivShift{1'b0}}});
  // a*32761 + 32800*|d|, everything divided by 2^10
  assign s_d  = src * $signed(ShrinkK)
              + $signed(AccW'({dm_q, 15'd0})) + $signed(AccW'({dm_q, 5'd0}));
  assign diff = $signed(rem_q - dv_q);

  assign status_o.d_zero   = (d_sel == '0);
  assign status_o.in_range = (s_q + dext > 0) && (s_q < (dext <<< TexW));
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.sel_b    = sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        if (frame_start_i) ord_q <= '0;
        k_q <= frame_start_i ? '0 : ord_q;
      end else if (cmd_i.advance) begin
        k_q <= (k_q == OrdLast) ? '0 : k_q + 2'd1;
      end
      if (cmd_i.out_load && !cmd_i.out_miss) ord_q <= k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (cmd_i.prod) begin
      p_cx_q <= $signed({1'b0, col_q}) * cfg_i.col_x;
      p_rx_q <= $signed({1'b0, row_q}) * cfg_i.row_x;
      p_ry_q <= $signed({1'b0, row_q}) * cfg_i.row_y;
      p_cz_q <= $signed({1'b0, col_q}) * cfg_i.col_z;
      p_rz_q <= $signed({1'b0, row_q}) * cfg_i.row_z;
    end
    if (cmd_i.sum) begin
      c_q[0] <= RayW'(cfg_i.org_x) + RayW'(p_cx_q) + RayW'(p_rx_q);
      c_q[1] <= RayW'(cfg_i.org_y) + RayW'(p_ry_q);
      c_q[2] <= RayW'(cfg_i.org_z) + RayW'(p_cz_q) + RayW'(p_rz_q);
    end
    if (cmd_i.setup) begin
      an_q   <= neg ? -NegW'(a_sel) : NegW'(a_sel);
      bn_q   <= neg ? -NegW'(b_sel) : NegW'(b_sel);
      dm_q   <= neg ? MagW'(-NegW'(d_sel)) : MagW'(d_sel);
      dpos_q <= ~neg;
      sel_q  <= 1'b0;
    end
    if (cmd_i.mul) s_q <= s_d;
    if (cmd_i.chk) begin
      // a slightly negative v truncates to zero
      rem_q <= s_q[AccW-1] ? '0 : s_q;
      dv_q  <= dext <<< QuotMsb;
      cnt_q <= CntW'(QuotMsb);
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (!diff[AccW-1]) rem_q <= diff;
      q_q   <= {q_q[TexW-2:0], ~diff[AccW-1]};
      dv_q  <= dv_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.store) begin
      if (sel_q) yi_q <= q_q;
      else xi_q <= q_q;
      sel_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      miss_o      <= cmd_i.out_miss;
      face_o      <= cmd_i.out_miss ? '0 : {k_q, dpos_q};
      texel_col_o <= cmd_i.out_miss ? '0 : xi_q;
      texel_row_o <= cmd_i.out_miss ? '0 : yi_q;
    end
  end

endmodule
`default_nettype wire

// File: src/cta_ctrl.sv
`default_nettype none
module cta_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  cta_pkg::status_t  status_i,
  output cta_pkg::cmd_t     cmd_o
);
  import cta_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROD  = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_STORE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] tries_q, tries_d;
  logic       miss_q, miss_d, oval_q, oval_d;

  assign out_valid_o = oval_q;

  always_comb begin
    state_d    = state_q;
    tries_d    = tries_q;
    miss_d     = miss_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    oval_d     = oval_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        tries_d   = '0;
        miss_d    = 1'b0;
        state_d   = S_SETUP;
      end
      S_SETUP: begin
        if (status_i.d_zero) begin
          if (tries_q == OrdLast) begin
            miss_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            tries_d       = tries_q + 2'd1;
          end
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (!status_i.in_range) begin
          if (tries_q == OrdLast) begin
            miss_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            tries_d       = tries_q + 2'd1;
            state_d       = S_SETUP;
          end
        end else begin
          cmd_o.chk = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = status_i.sel_b ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_miss = miss_q;
          oval_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tries_q <= '0;
      miss_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tries_q <= tries_d;
      miss_q  <= miss_d;
      oval_q  <= oval_d;
    end
  end

endmodule
`default_nettype wire

// File: src/cubemap_texel_address.sv
// cube-map face lookup: screen pixel in, cube face and texel position out
// input stream: one transfer per pixel, tdata holds column and row, tuser marks
//   the first pixel of a frame (restarts the axis order at x y z)
// output stream: one transfer per pixel with face, texel column and row; tuser
//   is the miss flag, set when no axis order lands inside a face
// apb port: eight ray registers at byte addresses 0 to 28, write them while idle
// search: the kept axis order is tried first, and each missed try advances the
//   axis order; the shared radix-2 divider runs 10 steps per texel index, two
//   indexes per try, with one pixel in flight at a time
// the output register holds a finished result, so a new pixel is taken while
//   the receiver stalls; a second result then waits in the controller until
//   the held one is transferred
// reset clears the registers to zero, the axis order to x y z and drops valid
`default_nettype none
module cubemap_texel_address (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // pixel_col [11:0], pixel_row [23:12]
  input  wire  [0:0]  s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // face [2:0], texel_col [12:3], texel_row [22:13]
  output logic [0:0]  m_axis_tuser,   // miss
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cta_pkg::*;

  cfg_t            cfg;
  cmd_t            cmd;
  status_t         status;
  logic [FaceW-1:0] face;
  logic [TexW-1:0]  tcol, trow;
  logic             miss;

  cta_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // fsm sequences product, sum, per-try setup, projection and division
  cta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cta_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .col_i         (s_axis_tdata[11:0]),
    .row_i         (s_axis_tdata[23:12]),
    .frame_start_i (s_axis_tuser[0]),
    .cmd_i         (cmd),
    .status_o      (status),
    .face_o        (face),
    .texel_col_o   (tcol),
    .texel_row_o   (trow),
    .miss_o        (miss)
  );

  assign m_axis_tdata = {1'b0, trow, tcol, face};
  assign m_axis_tuser = miss;

endmodule
`default_nettype wire
